// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is low.
`define QMM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qmm assertion failed");

// Expression that must never be true outside reset.
`define QMM_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `QMM_ASSERT(lbl, clk, rst_n, !(expr))

`endif

// ===== rtl/qmm_pkg.sv =====
package qmm_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int SPEED_W    = 12;
    localparam int THR_W      = 10;
    localparam int DRV_W      = 13;
    localparam int STEP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    // Widest mixed sum stays within +/-17.5k
    localparam int SUM_W      = 16;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = NUM_MOTORS * SPEED_W;
    localparam int OUT_USER_W = 1;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_HEIGHT = 2'd2,
        MODE_FAIL   = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_STEP = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_MAX_RST = 12'd700;
    localparam logic [SPEED_W-1:0] YAW_LIMIT_RST = 12'd100;
    localparam logic [STEP_W-1:0]  FAIL_STEP_RST = 8'd3;

    typedef logic [SPEED_W-1:0] t_speed;
    // element 0 front left, 1 front right, 2 rear left, 3 rear right
    typedef logic [NUM_MOTORS-1:0][SPEED_W-1:0] t_speeds;

    typedef struct packed {
        t_mode                    mode;
        logic [THR_W-1:0]         throttle;
        logic signed [DRV_W-1:0]  pitch_drive;
        logic signed [DRV_W-1:0]  roll_drive;
        logic signed [DRV_W-1:0]  yaw_drive;
        logic signed [DRV_W-1:0]  height_drive;
    } t_item;

    typedef struct packed {
        t_speeds speeds;
        logic    landed;
    } t_result;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_max;
        logic [SPEED_W-1:0] yaw_limit;
        logic [STEP_W-1:0]  fail_step;
    } t_cfg;

    function automatic t_speed clamp_speed(input logic signed [SUM_W-1:0] v,
                                           input logic [SPEED_W-1:0] hi);
        logic signed [SUM_W-1:0] hi_s;
        hi_s = $signed({{(SUM_W-SPEED_W){1'b0}}, hi});
        if (v > hi_s) begin
            return hi;
        end else if (v < 0) begin
            return '0;
        end
        return v[SPEED_W-1:0];
    endfunction

endpackage

// ===== rtl/quad_motor_mixer_with_failsafe_unit.sv =====
// Quad-X motor mixer with fail-safe ramp-down.
// Input stream: one beat per control tick. tuser carries the flight mode
// (idle, normal, fixed height, fail); tdata carries throttle and the pitch,
// roll, yaw and height controller outputs.
// Output stream: one beat per input beat with the four clamped motor speeds
// in tdata and the landed flag in tuser.
// Configuration: speed_max, yaw_limit and fail_step through a plain write
// port; write only while no beat is in flight.
// Stages: input register, then the mixer into the result register.
// Throughput: one beat per cycle while the output is not stalled.
// The mixer is a single adder/clamp pass; the stored speeds used by fail
// mode update on the same edge that loads the result register, so back to
// back beats see each other's speeds.
// Reset: stored speeds go to zero, registers to 700 / 100 / 3, both stages
// empty. A stalled output holds its beat; the input register takes one more
// beat and then deasserts tready until the output drains.
module quad_motor_mixer_with_failsafe_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // throttle[9:0], pitch_drive[22:10], roll_drive[35:23],
    // yaw_drive[48:36], height_drive[61:49], zero fill [63:62]
    input  logic [qmm_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // mode[1:0]
    input  logic [qmm_pkg::IN_USER_W-1:0]       i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // front_left[11:0], front_right[23:12], rear_left[35:24], rear_right[47:36]
    output logic [qmm_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // landed[0]
    output logic [qmm_pkg::OUT_USER_W-1:0]      o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [qmm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qmm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import qmm_pkg::*;

    `include "assert_macros.svh"

    logic    r_in_valid;
    t_item   r_in;
    t_item   n_in;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    t_speeds r_speed;
    t_cfg    r_cfg;
    logic    w_adv;
    logic    w_fire;
    logic    w_s_beat;

    assign w_adv    = !r_out_valid || i_m_axis_tready;
    assign w_fire   = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_s_beat = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in.mode         = t_mode'(i_s_axis_tuser[1:0]);
        n_in.throttle     = i_s_axis_tdata[9:0];
        n_in.pitch_drive  = $signed(i_s_axis_tdata[22:10]);
        n_in.roll_drive   = $signed(i_s_axis_tdata[35:23]);
        n_in.yaw_drive    = $signed(i_s_axis_tdata[48:36]);
        n_in.height_drive = $signed(i_s_axis_tdata[61:49]);
    end

    qmm_mix u_mix (
        .i_item   (r_in),
        .i_speeds (r_speed),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_speed     <= '0;
            r_cfg.speed_max <= SPEED_MAX_RST;
            r_cfg.yaw_limit <= YAW_LIMIT_RST;
            r_cfg.fail_step <= FAIL_STEP_RST;
        end else begin
            if (w_s_beat) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_speed     <= w_result.speeds;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SPEED_MAX: r_cfg.speed_max <= i_cfg_data[SPEED_W-1:0];
                    CFG_YAW_LIMIT: r_cfg.yaw_limit <= i_cfg_data[SPEED_W-1:0];
                    CFG_FAIL_STEP: r_cfg.fail_step <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_s_beat) begin
            r_in <= n_in;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.speeds;
    assign o_m_axis_tuser  = r_out.landed;

    // the pending beat always mirrors the stored speeds
    `QMM_ASSERT(a_out_matches_state, i_clk, i_rst_n,
        r_out_valid |-> (r_out.speeds == r_speed))
    `QMM_ASSERT_NEVER(a_landed_nonzero, i_clk, i_rst_n,
        r_out_valid && r_out.landed && (r_out.speeds != '0))
    `QMM_ASSERT(a_idle_zero, i_clk, i_rst_n,
        (w_fire && (r_in.mode == MODE_IDLE)) |=> (r_out.speeds == '0 && !r_out.landed))
    `QMM_ASSERT(a_landed_only_fail, i_clk, i_rst_n,
        (w_fire && (r_in.mode != MODE_FAIL)) |=> !r_out.landed)

endmodule

// ===== rtl/qmm_mix.sv =====
module qmm_mix (
    input  qmm_pkg::t_item   i_item,
    input  qmm_pkg::t_speeds i_speeds,
    input  qmm_pkg::t_cfg    i_cfg,
    output qmm_pkg::t_result o_result
);
    import qmm_pkg::*;

    localparam int YC_W = DRV_W + 1;

    logic signed [YC_W-1:0]  w_lim;
    logic signed [YC_W-1:0]  w_yaw;
    logic signed [YC_W-1:0]  w_yc;
    logic signed [SUM_W-1:0] w_thr;
    logic signed [SUM_W-1:0] w_p;
    logic signed [SUM_W-1:0] w_r;
    logic signed [SUM_W-1:0] w_y;
    logic signed [SUM_W-1:0] w_h;
    logic signed [SUM_W-1:0] w_mix [NUM_MOTORS];
    logic signed [SUM_W-1:0] w_dec [NUM_MOTORS];
    logic signed [SUM_W-1:0] w_raw [NUM_MOTORS];
    logic                    w_all_low;

    // symmetric yaw clamp
    always_comb begin
        w_lim = $signed({{(YC_W-SPEED_W){1'b0}}, i_cfg.yaw_limit});
        w_yaw = YC_W'(i_item.yaw_drive);
        if (w_yaw > w_lim) begin
            w_yc = w_lim;
        end else if (w_yaw < -w_lim) begin
            w_yc = -w_lim;
        end else begin
            w_yc = w_yaw;
        end
    end

    always_comb begin
        w_thr = $signed({{(SUM_W-THR_W){1'b0}}, i_item.throttle});
        w_p   = SUM_W'(i_item.pitch_drive);
        w_r   = SUM_W'(i_item.roll_drive);
        w_y   = SUM_W'(w_yc);
        w_h   = (i_item.mode == MODE_HEIGHT) ? SUM_W'(i_item.height_drive) : '0;
        w_mix[0] = w_thr + w_p - w_r + w_y + w_h;
        w_mix[1] = w_thr + w_p + w_r - w_y + w_h;
        w_mix[2] = w_thr - w_p - w_r - w_y + w_h;
        w_mix[3] = w_thr - w_p + w_r + w_y + w_h;
    end

    // fail ramp-down from the stored speeds
    always_comb begin
        w_all_low = 1'b1;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            w_dec[i] = $signed({{(SUM_W-SPEED_W){1'b0}}, i_speeds[i]})
                     - $signed({{(SUM_W-STEP_W){1'b0}}, i_cfg.fail_step});
            if (w_dec[i] > 0) begin
                w_all_low = 1'b0;
            end
        end
    end

    always_comb begin
        o_result.landed = 1'b0;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            w_raw[i] = '0;
        end
        unique case (i_item.mode)
            MODE_IDLE: begin
                for (int i = 0; i < NUM_MOTORS; i++) begin
                    w_raw[i] = '0;
                end
            end
            MODE_FAIL: begin
                for (int i = 0; i < NUM_MOTORS; i++) begin
                    w_raw[i] = w_dec[i];
                end
                o_result.landed = w_all_low;
            end
            default: begin
                for (int i = 0; i < NUM_MOTORS; i++) begin
                    w_raw[i] = w_mix[i];
                end
            end
        endcase
        for (int i = 0; i < NUM_MOTORS; i++) begin
            o_result.speeds[i] = clamp_speed(w_raw[i], i_cfg.speed_max);
        end
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qmm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PER_PHASE   = 180;
    localparam int NUM_PHASES  = 8;
    localparam int QUIET_LIMIT = 1000;

    // Predicts the four motor speeds and the landed flag of every tick and
    // holds them until the matching output beat arrives.
    class motor_mix_model;
        bit [SPEED_W-1:0] speed_max;
        bit [SPEED_W-1:0] yaw_limit;
        bit [STEP_W-1:0]  fail_step;
        bit [SPEED_W-1:0] level[NUM_MOTORS];
        t_result          awaited[$];
        int               ticks_checked;
        int               landed_seen;
        int               errors;

        function new();
            speed_max     = SPEED_MAX_RST;
            yaw_limit     = YAW_LIMIT_RST;
            fail_step     = FAIL_STEP_RST;
            foreach (level[i]) level[i] = '0;
            ticks_checked = 0;
            landed_seen   = 0;
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SPEED_MAX: speed_max = data;
                CFG_YAW_LIMIT: yaw_limit = data;
                CFG_FAIL_STEP: fail_step = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void apply_tick(t_item it);
            int      raw[NUM_MOTORS];
            int      thr, p, r, yc, hh, lim;
            bit      all_low;
            t_result want;
            thr     = int'(it.throttle);
            p       = int'($signed(it.pitch_drive));
            r       = int'($signed(it.roll_drive));
            yc      = int'($signed(it.yaw_drive));
            hh      = (it.mode == MODE_HEIGHT) ? int'($signed(it.height_drive)) : 0;
            lim     = int'(yaw_limit);
            all_low = 1'b1;
            if (yc > lim) yc = lim;
            if (yc < -lim) yc = -lim;
            case (it.mode)
                MODE_IDLE: begin
                    foreach (raw[i]) raw[i] = 0;
                end
                MODE_FAIL: begin
                    foreach (raw[i]) begin
                        raw[i] = int'(level[i]) - int'(fail_step);
                        if (raw[i] > 0) all_low = 1'b0;
                    end
                end
                default: begin
                    raw[0] = thr + p - r + yc + hh;
                    raw[1] = thr + p + r - yc + hh;
                    raw[2] = thr - p - r - yc + hh;
                    raw[3] = thr - p + r + yc + hh;
                end
            endcase
            foreach (raw[i]) begin
                if (raw[i] > int'(speed_max)) level[i] = speed_max;
                else if (raw[i] < 0) level[i] = '0;
                else level[i] = raw[i][SPEED_W-1:0];
                want.speeds[i] = level[i];
            end
            want.landed = (it.mode == MODE_FAIL) && all_low;
            awaited.push_back(want);
        endfunction

        function void check_speeds(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            t_result want;
            bit      bad;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: output beat with nothing awaited: %h", data);
                return;
            end
            want = awaited.pop_front();
            ticks_checked++;
            bad = 1'b0;
            for (int k = 0; k < NUM_MOTORS; k++) begin
                if (data[k*SPEED_W +: SPEED_W] !== want.speeds[k]) bad = 1'b1;
            end
            if (user[0] !== want.landed) bad = 1'b1;
            if (want.landed) landed_seen++;
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: tick %0d expected fl=%0d fr=%0d rl=%0d rr=%0d landed=%0d",
                             ticks_checked, want.speeds[0], want.speeds[1], want.speeds[2],
                             want.speeds[3], want.landed);
                    $display("       got              fl=%0d fr=%0d rl=%0d rr=%0d landed=%0d",
                             data[11:0], data[23:12], data[35:24], data[47:36], user[0]);
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    bit             tx_calm   = 1'b0;
    bit             rx_calm   = 1'b0;
    int             quiet     = 0;
    int             cfg_count = 0;
    motor_mix_model model;

    initial forever #5 clk = ~clk;

    quad_motor_mixer_with_failsafe_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    function automatic t_item make_tick(t_mode m, int thr, int p, int r, int y, int h);
        t_item it;
        it.mode         = m;
        it.throttle     = THR_W'(thr);
        it.pitch_drive  = DRV_W'(p);
        it.roll_drive   = DRV_W'(r);
        it.yaw_drive    = DRV_W'(y);
        it.height_drive = DRV_W'(h);
        return it;
    endfunction

    function automatic logic signed [DRV_W-1:0] draw_drive();
        int v;
        if ($urandom_range(0, 4) == 0) return DRV_W'($urandom);
        v = $urandom_range(0, 800);
        return DRV_W'(v - 400);
    endfunction

    function automatic t_item random_tick(t_mode m);
        int thr;
        thr = ($urandom_range(0, 7) == 0) ? $urandom_range(1001, 1023) : $urandom_range(0, 1000);
        return make_tick(m, thr, draw_drive(), draw_drive(), draw_drive(), draw_drive());
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_tick(t_item it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.height_drive, it.yaw_drive, it.roll_drive,
                     it.pitch_drive, it.throttle};
        s_tuser  <= it.mode;
        do @(posedge clk); while (!s_tready);
        model.apply_tick(it);
    endtask

    // Stop sending and wait until every awaited beat is out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (model.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        model.set_reg(idx, data);
        cfg_count++;
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(int smax, int ylim, int step);
        drain();
        write_reg(CFG_SPEED_MAX, CFG_DATA_W'(smax));
        write_reg(CFG_YAW_LIMIT, CFG_DATA_W'(ylim));
        write_reg(CFG_FAIL_STEP, CFG_DATA_W'(step));
    endtask

    // Output side: random stall before each beat.
    initial begin
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            model.check_speeds(m_tdata, m_tuser);
        end
    end

    // Watchdog: too long without a beat on either side.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int    sent, len, roll, items;
        bit    paused, noisy;
        t_mode m;
        model = new();
        items = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at reset register values
        send_tick(make_tick(MODE_IDLE, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_FAIL, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_NORMAL, 500, 0, 0, 0, 0));
        send_tick(make_tick(MODE_NORMAL, 1023, 4095, -4096, 4095, -4096));
        send_tick(make_tick(MODE_NORMAL, 0, -4096, 4095, -4096, 4095));
        send_tick(make_tick(MODE_HEIGHT, 300, 0, 0, 0, 4095));
        send_tick(make_tick(MODE_HEIGHT, 300, 0, 0, 0, -4096));
        send_tick(make_tick(MODE_HEIGHT, 400, 30, -20, 60, 50));
        send_tick(make_tick(MODE_NORMAL, 400, 0, 0, 100, 0));
        send_tick(make_tick(MODE_NORMAL, 400, 0, 0, 101, 0));
        send_tick(make_tick(MODE_NORMAL, 400, 0, 0, -101, 0));
        // small speeds ramped down until landed
        send_tick(make_tick(MODE_NORMAL, 5, 0, 0, 0, 0));
        send_tick(make_tick(MODE_FAIL, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_FAIL, 0, 0, 0, 0, 0));
        // two motors reach exactly zero on the second fail tick
        send_tick(make_tick(MODE_NORMAL, 3, 3, 0, 0, 0));
        send_tick(make_tick(MODE_FAIL, 1023, -1, -1, -1, -1));
        send_tick(make_tick(MODE_FAIL, 0, 0, 0, 0, 0));
        // speed_max zero forces everything to zero
        set_regs(0, 100, 3);
        send_tick(make_tick(MODE_NORMAL, 1000, 0, 0, 0, 0));
        send_tick(make_tick(MODE_FAIL, 0, 0, 0, 0, 0));
        // no yaw, fail step zero holds the speeds
        set_regs(4095, 0, 0);
        send_tick(make_tick(MODE_NORMAL, 1000, 0, 0, 4095, 0));
        send_tick(make_tick(MODE_FAIL, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_IDLE, 1000, 0, 0, 0, 0));
        send_tick(make_tick(MODE_FAIL, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_NORMAL, 1000, 0, 0, 0, 0));
        // lowered speed_max also clamps the fail ramp
        set_regs(200, 0, 5);
        write_reg(CFG_UNUSED, 12'hABC);
        send_tick(make_tick(MODE_FAIL, 0, 0, 0, 0, 0));
        items = 25;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_regs(SPEED_MAX_RST, YAW_LIMIT_RST, FAIL_STEP_RST);
                1: set_regs(4095, 4095, 255);
                2: set_regs(0, 0, 0);
                3: begin
                    set_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 4095));
                    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 4095)));
                end
                4: set_regs(4095, 50, 1);
                5: set_regs(100, $urandom_range(0, 4095), 12'hFFF);
                6: set_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095));
                default: set_regs(1, 0, 12'h101);
            endcase
            sent   = 0;
            paused = 1'b0;
            while (sent < PER_PHASE) begin
                tx_calm = ($urandom_range(0, 4) == 0);
                rx_calm = ($urandom_range(0, 4) == 0);
                noisy   = ($urandom_range(0, 9) == 0);
                roll    = $urandom_range(0, 99);
                m = (roll < 10) ? MODE_IDLE : (roll < 45) ? MODE_NORMAL :
                    (roll < 70) ? MODE_HEIGHT : MODE_FAIL;
                len = (m == MODE_FAIL) ? $urandom_range(3, 40) : $urandom_range(1, 12);
                for (int j = 0; j < len && sent < PER_PHASE; j++) begin
                    send_tick(random_tick(noisy ? t_mode'($urandom_range(0, 3)) : m));
                    sent++;
                end
                if (!paused && sent >= PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            items += sent;
        end

        drain();
        repeat (16) @(posedge clk);
        $display("Sent %0d ticks in all four modes over %0d register writes;", items, cfg_count);
        $display("checked %0d output beats, %0d of them landed", model.ticks_checked,
                 model.landed_seen);
        if (model.errors == 0 && model.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
